/* rtl/laplacian_edge_threshold_macros.svh */
// Assertion macros for the Laplacian edge threshold block.
// Included by files that carry concurrent checks; needs no other file.
`ifndef LAPLACIAN_EDGE_THRESHOLD_MACROS_SVH
`define LAPLACIAN_EDGE_THRESHOLD_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LPE_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, checked out of reset.
`define LPE_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* rtl/lpe_pkg.sv */
// Shared types and constants of the Laplacian edge threshold block.
// No dependencies.
package lpe_pkg;

  localparam logic [15:0] GRAY_WR   = 16'd19595;
  localparam logic [15:0] GRAY_WG   = 16'd38470;
  localparam logic [15:0] GRAY_WB   = 16'd7471;
  localparam logic [24:0] GRAY_HALF = 25'd32768;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2
  } cfg_reg_e;

  // Result slots of one pixel, in delivery order.
  localparam int SLOT_ABOVE_LEFT = 0;
  localparam int SLOT_LEFT       = 1;
  localparam int SLOT_ABOVE      = 2;
  localparam int SLOT_HERE       = 3;

  typedef struct packed {
    logic [3:0]  mask;
    logic [3:0]  edges;
    logic [10:0] col;
    logic [15:0] row;
  } bundle_t;

  typedef struct packed {
    logic [2:0] count;
    logic       push;
  } qstat_t;

  function automatic logic lap_edge(input logic [7:0] cen, input logic [7:0] l,
                                    input logic [7:0] r, input logic [7:0] u,
                                    input logic [7:0] d, input logic [7:0] thr);
    logic [10:0] v;
    logic [7:0]  vc;
    v  = {1'b0, cen, 2'b00} - {3'b0, l} - {3'b0, r} - {3'b0, u} - {3'b0, d};
    // Clamp to 255 before the compare so a full-scale threshold never fires.
    vc = (v[9:8] != 2'b00) ? 8'hFF : v[7:0];
    return !v[10] && (vc > thr);
  endfunction

endpackage

/* rtl/lpe_if.sv */
// Stream interfaces of the Laplacian edge threshold block.
// No dependencies.
interface lpe_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface lpe_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  edge_value;
  logic [10:0] out_col;
  logic [15:0] out_row;
  logic        last_of_item;
  logic        frame_done;
  modport source (output valid, edge_value, out_col, out_row, last_of_item, frame_done,
                  input ready);
  modport sink (input valid, edge_value, out_col, out_row, last_of_item, frame_done,
                output ready);
endinterface

/* rtl/laplacian_edge_threshold.sv */
// Top level of the streaming Laplacian edge threshold block.
// Depends on lpe_pkg, lpe_if, lpe_ram, lpe_window, lpe_resq and the macros header.
//
// RGB pixels enter in raster order at up to one per clock and become grey values
// (round of 0.299R+0.587G+0.114B). One RAM word per column holds the grey values of
// the two rows above; each pixel reads its column in the cycle it is taken and writes
// it back in the next cycle, with a forward path for frames one pixel wide. Each pixel
// yields its edge results (4-neighbour Laplacian, borders replicated,
// 255 when above edge_threshold) one row and one column behind the input. Results
// leave one per clock while the output is ready, from a four-bundle queue; inside a
// frame a pixel yields one result (two at the end of a row), in the last row two and
// at the last pixel of a row in the last row four, and new pixels are taken while
// earlier bundles drain. A request passes the request registers, the result queue and
// the output register before its first result appears. No clearing pass is needed.
`include "laplacian_edge_threshold_macros.svh"
module laplacian_edge_threshold #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpe_pix_if.sink     pix,
  lpe_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpe_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CMPW = ((CW + 1) > 12 ? (CW + 1) : 12) + 1;

  // Configuration registers.
  logic [11:0] fw_q;
  logic [15:0] fh_q;
  logic [7:0]  thr_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= 12'd1;
      fh_q  <= 16'd1;
      thr_q <= 8'd0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_WIDTH:  fw_q  <= pwdata[11:0];
        REG_HEIGHT: fh_q  <= pwdata[15:0];
        REG_THRESH: thr_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = {20'd0, fw_q};
      REG_HEIGHT: prdata = {16'd0, fh_q};
      REG_THRESH: prdata = {24'd0, thr_q};
      default:    prdata = 32'd0;
    endcase
  end

  // Effective frame size: zero counts as one, width saturates at the buffer depth.
  logic [CMPW-1:0] w_eff;
  logic [16:0]     h_eff;

  always_comb begin
    priority if (fw_q == 12'd0)                    w_eff = CMPW'(1);
    else if (CMPW'(fw_q) > CMPW'(MAX_WIDTH))       w_eff = CMPW'(MAX_WIDTH);
    else                                           w_eff = CMPW'(fw_q);
    h_eff = (fh_q == 16'd0) ? 17'd1 : {1'b0, fh_q};
  end

  // Raster position of the next request.
  logic [CW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;
  logic          end_row, last_row, accept;

  assign end_row  = (CMPW'(col_q) + CMPW'(1)) >= w_eff;
  assign last_row = ({1'b0, row_q} + 17'd1) >= h_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (end_row) begin
        col_d = '0;
        row_d = last_row ? 16'd0 : row_q + 16'd1;
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  // Credit check: every request in flight may need a queue slot.
  qstat_t     qstat;
  logic       b_valid_q;
  logic [3:0] credit_use;

  assign credit_use = {1'b0, qstat.count} + {3'b0, b_valid_q};
  assign pix.ready  = (credit_use < 4'd4);
  assign accept     = pix.valid && pix.ready;

  // Grey conversion, registered with the request.
  logic [24:0] gsum;
  assign gsum = 25'(pix.red) * 25'(GRAY_WR) + 25'(pix.green) * 25'(GRAY_WG)
              + 25'(pix.blue) * 25'(GRAY_WB) + GRAY_HALF;

  logic [7:0]    b_gray_q;
  logic [CW-1:0] b_col_q;
  logic [15:0]   b_row_q;
  logic          b_end_q, b_last_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_gray_q <= gsum[23:16];
      b_col_q  <= col_q;
      b_row_q  <= row_q;
      b_end_q  <= end_row;
      b_last_q <= last_row;
    end
  end

  // Line buffer: word holds {row above the previous, previous row} per column.
  logic [15:0] ram_rdata, line_word, wr_word, fwd_word_q;
  logic        fwd_hit_d, fwd_hit_q;

  assign wr_word   = {line_word[7:0], b_gray_q};
  assign fwd_hit_d = accept && b_valid_q && (b_col_q == col_q);
  assign line_word = fwd_hit_q ? fwd_word_q : ram_rdata;

  always_ff @(posedge clk_i) begin
    fwd_word_q <= wr_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
      fwd_hit_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      b_valid_q <= accept;
      fwd_hit_q <= fwd_hit_d;
    end
  end

  lpe_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i (wr_word),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  logic    push;
  bundle_t bundle;

  lpe_window #(.CW(CW)) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (b_valid_q),
    .up_i       (line_word[15:8]),
    .mid_i      (line_word[7:0]),
    .gray_i     (b_gray_q),
    .col_i      (b_col_q),
    .row_i      (b_row_q),
    .end_row_i  (b_end_q),
    .last_row_i (b_last_q),
    .thr_i      (thr_q),
    .push_o     (push),
    .bundle_o   (bundle)
  );

  lpe_resq u_resq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .res      (res),
    .stat_o   (qstat)
  );

  // Forwarding only happens when each row is one pixel wide.
  `LPE_ASSERT_IMP(a_fwd_narrow, clk_i, rst_ni, fwd_hit_d, w_eff == CMPW'(1))
  // The queue never takes a bundle while full.
  `LPE_ASSERT_IMP(a_q_room, clk_i, rst_ni, qstat.push, qstat.count < 3'd4)
  // The frame's final result always closes its pixel's results.
  `LPE_ASSERT_IMP(a_done_last, clk_i, rst_ni, res.valid && res.frame_done, res.last_of_item)
  // A request is followed by a write of its column.
  `LPE_ASSERT_NXT(a_wb, clk_i, rst_ni, accept, b_valid_q)
endmodule

/* rtl/lpe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/lpe_window.sv */
// 3x3 grey window and the four candidate edge decisions of one pixel.
// Depends on lpe_pkg.
module lpe_window #(
  parameter int CW = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [7:0]        up_i,
  input  logic [7:0]        mid_i,
  input  logic [7:0]        gray_i,
  input  logic [CW-1:0]     col_i,
  input  logic [15:0]       row_i,
  input  logic              end_row_i,
  input  logic              last_row_i,
  input  logic [7:0]        thr_i,
  output logic              push_o,
  output lpe_pkg::bundle_t  bundle_o
);
  import lpe_pkg::*;

  logic [7:0] win_q [9];
  logic [7:0] win_d [9];
  logic c0, c1, r0, r1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i*3+0] = win_q[i*3+1];
      win_d[i*3+1] = win_q[i*3+2];
    end
    win_d[2] = up_i;
    win_d[5] = mid_i;
    win_d[8] = gray_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (valid_i) begin
      for (int i = 0; i < 9; i++) win_q[i] <= win_d[i];
    end
  end

  assign c0 = (col_i == '0);
  assign c1 = (col_i == CW'(1));
  assign r0 = (row_i == 16'd0);
  assign r1 = (row_i == 16'd1);

  always_comb begin
    bundle_o.col  = 11'(col_i);
    bundle_o.row  = row_i;
    bundle_o.mask = '0;
    bundle_o.mask[SLOT_ABOVE_LEFT] = !c0 && !r0;
    bundle_o.mask[SLOT_LEFT]       = !c0 && last_row_i;
    bundle_o.mask[SLOT_ABOVE]      = end_row_i && !r0;
    bundle_o.mask[SLOT_HERE]       = end_row_i && last_row_i;
    bundle_o.edges = '0;
    bundle_o.edges[SLOT_ABOVE_LEFT] = lap_edge(win_d[4], c1 ? win_d[4] : win_d[3], win_d[5],
                                               r1 ? win_d[4] : win_d[1], win_d[7], thr_i);
    bundle_o.edges[SLOT_LEFT] = lap_edge(win_d[7], c1 ? win_d[7] : win_d[6], win_d[8],
                                         r0 ? win_d[7] : win_d[4], win_d[7], thr_i);
    bundle_o.edges[SLOT_ABOVE] = lap_edge(win_d[5], c0 ? win_d[5] : win_d[4], win_d[5],
                                          r1 ? win_d[5] : win_d[2], win_d[8], thr_i);
    bundle_o.edges[SLOT_HERE] = lap_edge(win_d[8], c0 ? win_d[8] : win_d[7], win_d[8],
                                         r0 ? win_d[8] : win_d[5], win_d[8], thr_i);
  end

  assign push_o = valid_i && (bundle_o.mask != 4'b0000);
endmodule

/* rtl/lpe_resq.sv */
// Result queue of per-pixel bundles, serializer and output register.
// Depends on lpe_pkg and lpe_if.
module lpe_resq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lpe_pkg::bundle_t   bundle_i,
  lpe_res_if.source          res,
  output lpe_pkg::qstat_t    stat_o
);
  import lpe_pkg::*;

  bundle_t    ent_q [4];
  logic [3:0] mask_q [4];
  logic [1:0] head_q, tail_q;
  logic [2:0] count_q;
  logic       ovalid_q;
  logic [7:0] oval_q;
  logic [10:0] ocol_q;
  logic [15:0] orow_q;
  logic       olast_q, odone_q;

  logic       emit, pop;
  logic [1:0] slot;
  logic [3:0] cur_mask, rem_mask;
  bundle_t    head;

  assign head     = ent_q[head_q];
  assign cur_mask = mask_q[head_q];
  assign emit     = (count_q != 3'd0) && (!ovalid_q || res.ready);

  always_comb begin
    priority if (cur_mask[SLOT_ABOVE_LEFT]) slot = 2'(SLOT_ABOVE_LEFT);
    else if (cur_mask[SLOT_LEFT])           slot = 2'(SLOT_LEFT);
    else if (cur_mask[SLOT_ABOVE])          slot = 2'(SLOT_ABOVE);
    else                                    slot = 2'(SLOT_HERE);
    rem_mask       = cur_mask;
    rem_mask[slot] = 1'b0;
  end

  assign pop = emit && (rem_mask == 4'b0000);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[tail_q]  <= bundle_i;
      mask_q[tail_q] <= bundle_i.mask;
    end
    if (emit) begin
      mask_q[head_q] <= rem_mask;
      oval_q  <= head.edges[slot] ? 8'd255 : 8'd0;
      ocol_q  <= slot[1] ? head.col : head.col - 11'd1;
      orow_q  <= slot[0] ? head.row : head.row - 16'd1;
      olast_q <= (rem_mask == 4'b0000);
      odone_q <= (slot == 2'(SLOT_HERE));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (push_i) tail_q <= tail_q + 2'd1;
      if (pop) head_q <= head_q + 2'd1;
      count_q <= count_q + {2'b0, push_i} - {2'b0, pop};
      if (emit) ovalid_q <= 1'b1;
      else if (res.ready) ovalid_q <= 1'b0;
    end
  end

  assign res.valid        = ovalid_q;
  assign res.edge_value   = oval_q;
  assign res.out_col      = ocol_q;
  assign res.out_row      = orow_q;
  assign res.last_of_item = olast_q;
  assign res.frame_done   = odone_q;

  assign stat_o.count = count_q;
  assign stat_o.push  = push_i;
endmodule

/* tb/laplacian_edge_threshold_tb.sv */
// Self-checking testbench of the Laplacian edge threshold block.
// Depends on lpe_pkg, lpe_if and the laplacian_edge_threshold RTL; no other file.
module laplacian_edge_threshold_tb;
  import lpe_pkg::*;

  typedef enum logic [1:0] {ENT_PIX, ENT_CFG, ENT_HOLD} ent_kind_e;

  typedef struct {
    ent_kind_e   kind;
    cfg_reg_e    reg_idx;
    logic [31:0] val;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    int          tx_pct;
    int          rx_pct;
  } pend_t;

  typedef struct {
    logic [7:0]  edge_value;
    logic [10:0] out_col;
    logic [15:0] out_row;
    logic        last_of_item;
    logic        frame_done;
  } edge_res_t;

  localparam int LINE_MAX   = 2048;
  localparam int QUIET_MIN  = 12;
  localparam int STALL_LIM  = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lpe_pix_if pix_if();
  lpe_res_if res_if();

  laplacian_edge_threshold dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix     (pix_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    pix_if.valid = 1'b0;
    pix_if.red   = '0;
    pix_if.green = '0;
    pix_if.blue  = '0;
    res_if.ready = 1'b0;
  end

  pend_t     pend_q[$];
  edge_res_t edge_q[$];
  int        errors = 0;
  int        tx_pct = 0, rx_pct = 0;
  int        quiet = 0;
  int        stall_cnt = 0;
  int        apb_st = 0;

  // Predictor state: two grey lines, the 3x3 window, the raster position and
  // the register copies.
  logic [7:0]  gray_above[LINE_MAX];
  logic [7:0]  gray_line[LINE_MAX];
  logic [7:0]  win_px[9];
  int          px_col = 0, px_row = 0;
  logic [11:0] cfg_w = 12'd1;
  logic [15:0] cfg_h = 16'd1;
  logic [7:0]  cfg_t = 8'd0;

  initial begin
    for (int i = 0; i < LINE_MAX; i++) begin
      gray_above[i] = '0;
      gray_line[i]  = '0;
    end
    for (int i = 0; i < 9; i++) win_px[i] = '0;
  end

  // Edge decision for window cell (wr, wc); a missing neighbour is the centre.
  function automatic logic [7:0] edge_at(int wr, int wc, bit le, bit re, bit te, bit be);
    int cen, l, r, u, d, v;
    cen = win_px[wr*3+wc];
    l = (le || wc == 0) ? cen : win_px[wr*3+wc-1];
    r = (re || wc == 2) ? cen : win_px[wr*3+wc+1];
    u = (te || wr == 0) ? cen : win_px[(wr-1)*3+wc];
    d = (be || wr == 2) ? cen : win_px[(wr+1)*3+wc];
    v = 4*cen - l - r - u - d;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return (v > cfg_t) ? 8'd255 : 8'd0;
  endfunction

  task automatic push_edge(logic [7:0] ev, int col, int row, bit done);
    edge_res_t e;
    e.edge_value   = ev;
    e.out_col      = col[10:0];
    e.out_row      = row[15:0];
    e.last_of_item = 1'b0;
    e.frame_done   = done;
    edge_q.push_back(e);
  endtask

  // Advance the predictor by one pixel and queue the results it releases.
  task automatic predict_edges(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
    int w, h, c, r, n0;
    logic [31:0] acc;
    logic [7:0]  g, up, mid;
    bit end_row, last_row;
    w = cfg_w;
    h = cfg_h;
    if (w == 0) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    if (h == 0) h = 1;
    c = px_col;
    r = px_row;
    end_row  = (c + 1 >= w);
    last_row = (r + 1 >= h);
    acc = 32'd19595*rd + 32'd38470*gr + 32'd7471*bl + 32'd32768;
    g = acc[23:16];
    up  = gray_above[c];
    mid = gray_line[c];
    gray_above[c] = mid;
    gray_line[c]  = g;
    for (int i = 0; i < 3; i++) begin
      win_px[i*3]   = win_px[i*3+1];
      win_px[i*3+1] = win_px[i*3+2];
    end
    win_px[2] = up;
    win_px[5] = mid;
    win_px[8] = g;
    n0 = edge_q.size();
    if (c >= 1) begin
      if (r >= 1) push_edge(edge_at(1, 1, c == 1, 0, r == 1, 0), c-1, r-1, 0);
      if (last_row) push_edge(edge_at(2, 1, c == 1, 0, r == 0, 1), c-1, r, 0);
    end
    if (end_row) begin
      if (r >= 1) push_edge(edge_at(1, 2, c == 0, 1, r == 1, 0), c, r-1, 0);
      if (last_row) push_edge(edge_at(2, 2, c == 0, 1, r == 0, 1), c, r, 1);
    end
    if (edge_q.size() > n0) edge_q[edge_q.size()-1].last_of_item = 1'b1;
    if (end_row) begin
      px_col = 0;
      px_row = last_row ? 0 : ((r + 1) & 16'hFFFF);
    end else begin
      px_col = c + 1;
    end
  endtask

  // Driver: pixel requests, register writes and hold-offs, in queue order.
  always @(posedge clk_i) begin
    bit   acc_pix, nxt_valid, nxt_sel, nxt_en;
    pend_t p;
    acc_pix   = pix_if.valid && pix_if.ready;
    nxt_valid = pix_if.valid && !acc_pix;
    nxt_sel   = psel;
    nxt_en    = penable;
    if (rst_ni) begin
      if (acc_pix) predict_edges(pix_if.red, pix_if.green, pix_if.blue);
      if (acc_pix || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
      if (!nxt_valid && pend_q.size() > 0) begin
        p = pend_q[0];
        case (p.kind)
          ENT_PIX: begin
            tx_pct = p.tx_pct;
            rx_pct = p.rx_pct;
            if ($urandom_range(99) >= tx_pct) begin
              void'(pend_q.pop_front());
              nxt_valid = 1'b1;
              pix_if.red   <= p.red;
              pix_if.green <= p.green;
              pix_if.blue  <= p.blue;
            end
          end
          ENT_HOLD: begin
            if (edge_q.size() == 0) void'(pend_q.pop_front());
          end
          default: begin
            // Write only once the block has drained and sat quiet a while.
            case (apb_st)
              0: if (edge_q.size() == 0 && quiet >= QUIET_MIN && !pix_if.valid) begin
                nxt_sel = 1'b1;
                pwrite <= 1'b1;
                paddr  <= {p.reg_idx, 2'b00};
                pwdata <= p.val;
                apb_st = 1;
              end
              1: begin
                nxt_en = 1'b1;
                apb_st = 2;
              end
              default: begin
                if (psel && penable && pwrite && pready) begin
                  case (p.reg_idx)
                    REG_WIDTH:  cfg_w = p.val[11:0];
                    REG_HEIGHT: cfg_h = p.val[15:0];
                    default:    cfg_t = p.val[7:0];
                  endcase
                  nxt_sel = 1'b0;
                  nxt_en  = 1'b0;
                  apb_st  = 0;
                  quiet   = 0;
                  void'(pend_q.pop_front());
                end
              end
            endcase
          end
        endcase
      end
    end
    pix_if.valid <= nxt_valid;
    psel    <= nxt_sel;
    penable <= nxt_en;
    res_if.ready <= ($urandom_range(99) >= rx_pct);
  end

  // Monitor: compare each result against the oldest expectation.
  always @(posedge clk_i) begin
    edge_res_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (edge_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result edge=%0d col=%0d row=%0d", res_if.edge_value,
                   res_if.out_col, res_if.out_row);
      end else begin
        e = edge_q.pop_front();
        if (e.edge_value !== res_if.edge_value || e.out_col !== res_if.out_col ||
            e.out_row !== res_if.out_row || e.last_of_item !== res_if.last_of_item ||
            e.frame_done !== res_if.frame_done) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp edge=%0d col=%0d row=%0d last=%0b done=%0b, got edge=%0d col=%0d row=%0d last=%0b done=%0b",
                     e.edge_value, e.out_col, e.out_row, e.last_of_item, e.frame_done,
                     res_if.edge_value, res_if.out_col, res_if.out_row,
                     res_if.last_of_item, res_if.frame_done);
        end
      end
    end
  end

  // Watchdog: count cycles with no request moving on any port.
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) || psel)
      stall_cnt = 0;
    else
      stall_cnt++;
    if (stall_cnt >= STALL_LIM) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic add_cfg(cfg_reg_e idx, logic [31:0] v);
    pend_t p;
    p.kind = ENT_CFG;
    p.reg_idx = idx;
    p.val = v;
    pend_q.push_back(p);
  endtask

  task automatic add_hold();
    pend_t p;
    p.kind = ENT_HOLD;
    pend_q.push_back(p);
  endtask

  task automatic add_pix(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl, int tp, int rp);
    pend_t p;
    p.kind = ENT_PIX;
    p.red = rd;
    p.green = gr;
    p.blue = bl;
    p.tx_pct = tp;
    p.rx_pct = rp;
    pend_q.push_back(p);
  endtask

  // Mix of fully random channels and saturated ones to give sharp edges.
  function automatic logic [7:0] chan();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic add_frame(int w, int h, int t, int npix, int tp, int rp);
    add_cfg(REG_WIDTH, w);
    add_cfg(REG_HEIGHT, h);
    add_cfg(REG_THRESH, t);
    for (int i = 0; i < npix; i++) add_pix(chan(), chan(), chan(), tp, rp);
  endtask

  initial begin
    int w, h, n;
    int tx_tab[4];
    int rx_tab[4];
    tx_tab = '{0, 85, 0, 14};
    rx_tab = '{0, 0, 85, 14};
    // Directed: channel extremes on a 4x3 frame, zero threshold.
    add_cfg(REG_WIDTH, 4);
    add_cfg(REG_HEIGHT, 3);
    add_cfg(REG_THRESH, 0);
    add_pix(8'd0, 8'd0, 8'd0, 0, 0);
    add_pix(8'd255, 8'd255, 8'd255, 0, 0);
    add_pix(8'd255, 8'd0, 8'd0, 0, 0);
    add_pix(8'd0, 8'd255, 8'd0, 0, 0);
    add_pix(8'd0, 8'd0, 8'd255, 0, 0);
    add_pix(8'd255, 8'd255, 8'd255, 0, 0);
    add_pix(8'd0, 8'd0, 8'd0, 0, 0);
    add_pix(8'd128, 8'd128, 8'd128, 0, 0);
    add_pix(8'd255, 8'd255, 8'd255, 0, 0);
    add_pix(8'd1, 8'd2, 8'd3, 0, 0);
    add_pix(8'd0, 8'd0, 8'd0, 0, 0);
    add_pix(8'd255, 8'd255, 8'd255, 0, 0);
    add_hold();
    // Zero width and height fall back to one pixel; top threshold never fires.
    add_frame(0, 0, 255, 3, 0, 0);
    // Random frames under each idling mix.
    for (int ph = 0; ph < 4; ph++) begin
      n = 0;
      while (n < 45) begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
        add_frame(w, h, $urandom_range(255), w*h, tx_tab[ph], rx_tab[ph]);
        n += w*h;
        if ($urandom_range(3) == 0) add_hold();
      end
    end
    // Tall frame cut short by shrinking the height to one row.
    add_frame(1, 65535, $urandom_range(255), 20, 14, 14);
    add_frame(1, 1, $urandom_range(255), 1, 0, 0);
    // Width beyond the line length saturates to the full line; cut the row short.
    add_frame(4095, 1, $urandom_range(255), 24, 0, 14);
    // The first pixel here closes the open row under the narrower width.
    add_frame(4, 2, 0, 8, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pend_q.size() == 0 && edge_q.size() == 0 && !pix_if.valid);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && edge_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
